[src/wdis_pkg.sv]
`timescale 1ns / 1ps

package wdis_pkg;

  // store sizes; the port widths are drawn for these values
  localparam int MAX_CELLS       = 1024;
  localparam int MAX_FACES       = 4;
  localparam int MAX_FACE_POINTS = 8;

  // request operation codes
  typedef enum logic [2:0] {
    OP_WR_STATUS = 3'd0,
    OP_WR_NBR    = 3'd1,
    OP_WR_MASK   = 3'd2,
    OP_SCAN      = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_FACE_COUNT      = 2'd0;
  localparam logic [1:0] CFG_POINTS_PER_FACE = 2'd1;
  localparam logic [1:0] CFG_POINTS_PER_CELL = 2'd2;

  // configuration reset values
  localparam logic [2:0] FACE_COUNT_RST      = 3'd3;
  localparam logic [3:0] POINTS_PER_FACE_RST = 4'd2;
  localparam logic [6:0] POINTS_PER_CELL_RST = 7'd3;

  // status code of a wet cell
  localparam logic [2:0] WET_CODE = 3'd4;

  // scan sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_NB_RD,
    S_NB_CHK,
    S_DRY_CHK,
    S_BK,
    S_EM_START,
    S_EM
  } state_t;

  // one result on its way to the output register
  typedef struct packed {
    logic        valid;
    logic [10:0] wet_cell;
    logic [2:0]  wet_face;
    logic [10:0] dry_cell;
    logic [2:0]  dry_face;
    logic        found;
    logic [2:0]  slot;
    logic [16:0] base;
    logic [11:0] ifn;
    logic [10:0] wet_total;
    logic        last;
  } emit_req_t;

endpackage

[src/wdis_ram.sv]
`timescale 1ns / 1ps

module wdis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/wdis_emit.sv]
`timescale 1ns / 1ps

module wdis_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  wdis_pkg::emit_req_t em,
  input  logic [6:0]          mask_node,
  output logic                out_strobe,
  output logic [10:0]         out_wet_cell,
  output logic [2:0]          out_wet_face,
  output logic [10:0]         out_dry_cell,
  output logic [2:0]          out_dry_face,
  output logic                out_back_face_found,
  output logic [2:0]          out_point_slot,
  output logic [16:0]         out_global_node,
  output logic [11:0]         out_interface_number,
  output logic [10:0]         out_wet_total,
  output logic                out_last
);

  import wdis_pkg::*;

  logic        strobe_r;
  logic [10:0] wet_cell_r;
  logic [2:0]  wet_face_r;
  logic [10:0] dry_cell_r;
  logic [2:0]  dry_face_r;
  logic        found_r;
  logic [2:0]  slot_r;
  logic [16:0] node_r;
  logic [11:0] ifn_r;
  logic [10:0] wet_total_r;
  logic        last_r;

  // strobe: one cycle per result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= em.valid;
    end
  end

  // result register; node = cell base + mask node from the RAM
  always_ff @(posedge clk) begin
    if (em.valid) begin
      wet_cell_r  <= em.wet_cell;
      wet_face_r  <= em.wet_face;
      dry_cell_r  <= em.dry_cell;
      dry_face_r  <= em.dry_face;
      found_r     <= em.found;
      slot_r      <= em.slot;
      node_r      <= em.base + 17'(mask_node);
      ifn_r       <= em.ifn;
      wet_total_r <= em.wet_total;
      last_r      <= em.last;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_wet_cell         = wet_cell_r;
  assign out_wet_face         = wet_face_r;
  assign out_dry_cell         = dry_cell_r;
  assign out_dry_face         = dry_face_r;
  assign out_back_face_found  = found_r;
  assign out_point_slot       = slot_r;
  assign out_global_node      = node_r;
  assign out_interface_number = ifn_r;
  assign out_wet_total        = wet_total_r;
  assign out_last             = last_r;

endmodule

[src/wdis_seq.sv]
`timescale 1ns / 1ps

module wdis_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_op,
  input  logic [9:0]          in_cell_req,
  input  logic [1:0]          in_face,
  input  logic [2:0]          in_point,
  input  logic [2:0]          in_status_code,
  input  logic [10:0]         in_neighbour_cell,
  input  logic [6:0]          in_mask_node,
  input  logic [2:0]          face_count,
  input  logic [3:0]          points_per_face,
  input  logic [6:0]          points_per_cell,
  output logic                busy,
  output wdis_pkg::emit_req_t em,
  output logic [6:0]          mask_rdata
);

  import wdis_pkg::*;

  localparam int CW     = $clog2(MAX_CELLS);
  localparam int FW     = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int KW     = (MAX_FACE_POINTS > 1) ? $clog2(MAX_FACE_POINTS) : 1;
  localparam int NFW    = $clog2(MAX_FACES + 1);
  localparam int NPW    = $clog2(MAX_FACE_POINTS + 1);
  localparam int NDEPTH = MAX_CELLS * MAX_FACES;
  localparam int NAW    = $clog2(NDEPTH);
  localparam int MDEPTH = MAX_FACES * MAX_FACE_POINTS;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cell_r, cell_nxt;
  logic [16:0]       base_r, base_nxt;
  logic [FW-1:0]     j_r, j_nxt;
  logic [FW-1:0]     s_r, s_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [10:0]       nb_r, nb_nxt;
  logic              bk_found_r, bk_found_nxt;
  logic [2:0]        bk_face_r, bk_face_nxt;
  logic [12:0]       icount_r, icount_nxt;
  logic [10:0]       wcount_r, wcount_nxt;
  logic [MAX_FACES-1:0] if_r, if_nxt;
  logic [10:0]       fnb_r [MAX_FACES];
  logic [10:0]       fnb_nxt [MAX_FACES];
  logic [2:0]        fback_r [MAX_FACES];
  logic [2:0]        fback_nxt [MAX_FACES];
  logic              ffound_r [MAX_FACES];
  logic              ffound_nxt [MAX_FACES];
  logic [11:0]       fifn_r [MAX_FACES];
  logic [11:0]       fifn_nxt [MAX_FACES];
  emit_req_t         em_r, em_nxt;

  logic              accept;
  logic              in_range;
  logic [NFW-1:0]    nf;
  logic [NPW-1:0]    np;
  logic              hit;
  logic              found_now;
  logic [2:0]        back_now;
  logic [FW-1:0]     first_j, next_j;
  logic              has_first, has_next;

  // store ports
  logic              st_we, nb_we, mk_we;
  logic [CW-1:0]     st_addr;
  logic [NAW-1:0]    nb_addr;
  logic [MAW-1:0]    mk_addr;
  logic [2:0]        st_rdata;
  logic [10:0]       nb_rdata;

  wdis_ram #(.WIDTH(3), .DEPTH(MAX_CELLS)) u_status (
    .clk   (clk),
    .we    (st_we),
    .addr  (st_addr),
    .wdata (in_status_code),
    .rdata (st_rdata)
  );

  wdis_ram #(.WIDTH(11), .DEPTH(NDEPTH)) u_nbr (
    .clk   (clk),
    .we    (nb_we),
    .addr  (nb_addr),
    .wdata (in_neighbour_cell),
    .rdata (nb_rdata)
  );

  wdis_ram #(.WIDTH(7), .DEPTH(MDEPTH)) u_mask (
    .clk   (clk),
    .we    (mk_we),
    .addr  (mk_addr),
    .wdata (in_mask_node),
    .rdata (mask_rdata)
  );

  assign busy     = (state_r != S_IDLE) || em_r.valid;
  assign accept   = start && !busy;
  assign in_range = 32'(in_cell_req) < MAX_CELLS;
  assign nf = (32'(face_count) > MAX_FACES) ? NFW'(MAX_FACES) : NFW'(face_count);
  assign np = (32'(points_per_face) > MAX_FACE_POINTS) ? NPW'(MAX_FACE_POINTS)
                                                        : NPW'(points_per_face);
  assign em = em_r;

  // back-face compare, the last match wins
  assign hit       = 32'(nb_rdata) == (32'(cell_r) + 32'd1);
  assign found_now = hit ? 1'b1 : bk_found_r;
  assign back_now  = hit ? 3'(32'(s_r) + 32'd1) : bk_face_r;

  // first interface face, and the next one after the current face
  always_comb begin
    first_j   = '0;
    has_first = 1'b0;
    next_j    = '0;
    has_next  = 1'b0;
    for (int i = MAX_FACES - 1; i >= 0; i--) begin
      if (if_r[i]) begin
        first_j   = FW'(i);
        has_first = 1'b1;
        if (i > 32'(j_r)) begin
          next_j   = FW'(i);
          has_next = 1'b1;
        end
      end
    end
  end

  // sequencer: next state, store ports and pipeline loads
  always_comb begin
    state_nxt    = state_r;
    cell_nxt     = cell_r;
    base_nxt     = base_r;
    j_nxt        = j_r;
    s_nxt        = s_r;
    k_nxt        = k_r;
    nb_nxt       = nb_r;
    bk_found_nxt = bk_found_r;
    bk_face_nxt  = bk_face_r;
    icount_nxt   = icount_r;
    wcount_nxt   = wcount_r;
    if_nxt       = if_r;
    fnb_nxt      = fnb_r;
    fback_nxt    = fback_r;
    ffound_nxt   = ffound_r;
    fifn_nxt     = fifn_r;
    em_nxt       = em_r;
    em_nxt.valid = 1'b0;
    st_we        = 1'b0;
    nb_we        = 1'b0;
    mk_we        = 1'b0;
    st_addr      = cell_r;
    nb_addr      = NAW'(32'(cell_r) * MAX_FACES + 32'(j_r));
    mk_addr      = MAW'(32'(j_r) * MAX_FACE_POINTS + 32'(k_r));

    unique case (state_r)
      S_IDLE: begin
        st_addr = CW'(in_cell_req);
        nb_addr = NAW'(32'(in_cell_req) * MAX_FACES + 32'(in_face));
        mk_addr = MAW'(32'(in_face) * MAX_FACE_POINTS + 32'(in_point));
        if (accept) begin
          unique case (in_op)
            OP_WR_STATUS: st_we = in_range;
            OP_WR_NBR:    nb_we = in_range && (32'(in_face) < MAX_FACES);
            OP_WR_MASK: begin
              mk_we = in_range && (32'(in_face) < MAX_FACES)
                      && (32'(in_point) < MAX_FACE_POINTS);
            end
            OP_SCAN: begin
              if (in_range) begin
                cell_nxt  = CW'(in_cell_req);
                state_nxt = S_CHK;
              end
            end
            OP_CLEAR: begin
              icount_nxt = '0;
              wcount_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // own status is back; work out the node base once per scan
      S_CHK: begin
        base_nxt = 17'(cell_r) * 17'(points_per_cell);
        if (st_rdata == WET_CODE) begin
          wcount_nxt = wcount_r + 11'd1;
          j_nxt      = '0;
          if_nxt     = '0;
          state_nxt  = (nf == '0) ? S_IDLE : S_NB_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_NB_RD: begin
        state_nxt = S_NB_CHK;
      end

      // neighbour is back; fetch its status if it names a cell
      S_NB_CHK: begin
        nb_nxt  = nb_rdata;
        st_addr = CW'(nb_rdata - 11'd1);
        if (nb_rdata != 11'd0 && 32'(nb_rdata) <= MAX_CELLS) begin
          state_nxt = S_DRY_CHK;
        end else if (32'(j_r) + 32'd1 < 32'(nf)) begin
          j_nxt     = j_r + FW'(1);
          state_nxt = S_NB_RD;
        end else begin
          state_nxt = S_EM_START;
        end
      end

      // dry neighbour starts the back-face search
      S_DRY_CHK: begin
        nb_addr = NAW'((32'(nb_r) - 32'd1) * MAX_FACES);
        if (st_rdata != WET_CODE) begin
          s_nxt        = '0;
          bk_found_nxt = 1'b0;
          bk_face_nxt  = 3'd0;
          state_nxt    = S_BK;
        end else if (32'(j_r) + 32'd1 < 32'(nf)) begin
          j_nxt     = j_r + FW'(1);
          state_nxt = S_NB_RD;
        end else begin
          state_nxt = S_EM_START;
        end
      end

      // one neighbour face compared per cycle
      S_BK: begin
        bk_found_nxt = found_now;
        bk_face_nxt  = back_now;
        nb_addr      = NAW'((32'(nb_r) - 32'd1) * MAX_FACES + 32'(s_r) + 32'd1);
        if (32'(s_r) + 32'd1 < 32'(nf)) begin
          s_nxt = s_r + FW'(1);
        end else begin
          if_nxt[j_r]     = 1'b1;
          fnb_nxt[j_r]    = nb_r;
          fback_nxt[j_r]  = back_now;
          ffound_nxt[j_r] = found_now;
          fifn_nxt[j_r]   = icount_r[11:0];
          icount_nxt      = icount_r + 13'd1;
          if (32'(j_r) + 32'd1 < 32'(nf)) begin
            j_nxt     = j_r + FW'(1);
            state_nxt = S_NB_RD;
          end else begin
            state_nxt = S_EM_START;
          end
        end
      end

      S_EM_START: begin
        if (has_first && np != '0) begin
          j_nxt     = first_j;
          k_nxt     = '0;
          state_nxt = S_EM;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // one face point per cycle; mask read goes out with the request
      S_EM: begin
        em_nxt.valid     = 1'b1;
        em_nxt.wet_cell  = 11'(32'(cell_r) + 32'd1);
        em_nxt.wet_face  = 3'(32'(j_r) + 32'd1);
        em_nxt.dry_cell  = fnb_r[j_r];
        em_nxt.dry_face  = fback_r[j_r];
        em_nxt.found     = ffound_r[j_r];
        em_nxt.slot      = 3'(k_r);
        em_nxt.base      = base_r;
        em_nxt.ifn       = fifn_r[j_r];
        em_nxt.wet_total = wcount_r;
        em_nxt.last      = 1'b0;
        if (32'(k_r) + 32'd1 == 32'(np)) begin
          k_nxt = '0;
          if (has_next) begin
            j_nxt = next_j;
          end else begin
            em_nxt.last = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and the outgoing request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      icount_r   <= '0;
      wcount_r   <= '0;
      if_r       <= '0;
      em_r.valid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      icount_r <= icount_nxt;
      wcount_r <= wcount_nxt;
      if_r     <= if_nxt;
      em_r     <= em_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    base_r     <= base_nxt;
    j_r        <= j_nxt;
    s_r        <= s_nxt;
    k_r        <= k_nxt;
    nb_r       <= nb_nxt;
    bk_found_r <= bk_found_nxt;
    bk_face_r  <= bk_face_nxt;
    fnb_r      <= fnb_nxt;
    fback_r    <= fback_nxt;
    ffound_r   <= ffound_nxt;
    fifn_r     <= fifn_nxt;
  end

endmodule

[src/wet_dry_interface_scan.sv]
`timescale 1ns / 1ps

// Wet/dry interface scan over a cell mesh.
// Requests arrive on in_* and are taken when start is high and busy is low.
// Ops: status, neighbour and face-mask loads, a cell scan, and a count clear.
// Loads and clear leave busy low, and the next request may
// follow at once. A scan reads the cell status, then for each face the
// neighbour and its status; a dry neighbour's faces are searched one per
// cycle on the single neighbour store port. Each interface face then yields
// one result per face point, one per cycle, through a two-stage output path.
// Results appear on out_* for one cycle each, flagged by out_strobe; the
// receiver cannot stall, and out_last marks the final result of a scan.
// Reset zeroes the counters and loads face_count 3, points_per_face 2 and
// points_per_cell 3; the stores are undefined until loaded, no clearing pass.
// cfg_we writes register cfg_index; write only while busy is low.
module wet_dry_interface_scan (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [9:0]  in_cell_req,
  input  logic [1:0]  in_face,
  input  logic [2:0]  in_point,
  input  logic [2:0]  in_status_code,
  input  logic [10:0] in_neighbour_cell,
  input  logic [6:0]  in_mask_node,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [10:0] out_wet_cell,
  output logic [2:0]  out_wet_face,
  output logic [10:0] out_dry_cell,
  output logic [2:0]  out_dry_face,
  output logic        out_back_face_found,
  output logic [2:0]  out_point_slot,
  output logic [16:0] out_global_node,
  output logic [11:0] out_interface_number,
  output logic [10:0] out_wet_total,
  output logic        out_last
);

  import wdis_pkg::*;

  logic [2:0] face_count_r, face_count_nxt;
  logic [3:0] ppf_r, ppf_nxt;
  logic [6:0] ppc_r, ppc_nxt;
  emit_req_t  em;
  logic [6:0] mask_rdata;

  // configuration write decode
  always_comb begin
    face_count_nxt = face_count_r;
    ppf_nxt        = ppf_r;
    ppc_nxt        = ppc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FACE_COUNT:      face_count_nxt = cfg_wdata[2:0];
        CFG_POINTS_PER_FACE: ppf_nxt        = cfg_wdata[3:0];
        CFG_POINTS_PER_CELL: ppc_nxt        = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_count_r <= FACE_COUNT_RST;
      ppf_r        <= POINTS_PER_FACE_RST;
      ppc_r        <= POINTS_PER_CELL_RST;
    end else begin
      face_count_r <= face_count_nxt;
      ppf_r        <= ppf_nxt;
      ppc_r        <= ppc_nxt;
    end
  end

  wdis_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_op             (in_op),
    .in_cell_req       (in_cell_req),
    .in_face           (in_face),
    .in_point          (in_point),
    .in_status_code    (in_status_code),
    .in_neighbour_cell (in_neighbour_cell),
    .in_mask_node      (in_mask_node),
    .face_count        (face_count_r),
    .points_per_face   (ppf_r),
    .points_per_cell   (ppc_r),
    .busy              (busy),
    .em                (em),
    .mask_rdata        (mask_rdata)
  );

  wdis_emit u_emit (
    .clk                  (clk),
    .rst_n                (rst_n),
    .em                   (em),
    .mask_node            (mask_rdata),
    .out_strobe           (out_strobe),
    .out_wet_cell         (out_wet_cell),
    .out_wet_face         (out_wet_face),
    .out_dry_cell         (out_dry_cell),
    .out_dry_face         (out_dry_face),
    .out_back_face_found  (out_back_face_found),
    .out_point_slot       (out_point_slot),
    .out_global_node      (out_global_node),
    .out_interface_number (out_interface_number),
    .out_wet_total        (out_wet_total),
    .out_last             (out_last)
  );

endmodule

[tb/sv/tb_wet_dry_interface_scan.sv]
`timescale 1ns / 1ps

module tb_wet_dry_interface_scan;
  import wdis_pkg::*;

  localparam int MAX_FPTS      = 8;
  localparam int POOL_SIZE     = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  // op codes the block leaves unused
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  cell_req;
    logic [1:0]  face;
    logic [2:0]  point;
    logic [2:0]  status;
    logic [10:0] nbr;
    logic [6:0]  mask;
  } scan_req_t;

  typedef struct packed {
    logic [10:0] wet_cell;
    logic [2:0]  wet_face;
    logic [10:0] dry_cell;
    logic [2:0]  dry_face;
    logic        found;
    logic [2:0]  slot;
    logic [16:0] gnode;
    logic [11:0] ifn;
    logic [10:0] wet_total;
    logic        last;
  } node_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [9:0]  in_cell_req = '0;
  logic [1:0]  in_face = '0;
  logic [2:0]  in_point = '0;
  logic [2:0]  in_status_code = '0;
  logic [10:0] in_neighbour_cell = '0;
  logic [6:0]  in_mask_node = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_wdata = '0;
  logic        out_strobe;
  logic [10:0] out_wet_cell;
  logic [2:0]  out_wet_face;
  logic [10:0] out_dry_cell;
  logic [2:0]  out_dry_face;
  logic        out_back_face_found;
  logic [2:0]  out_point_slot;
  logic [16:0] out_global_node;
  logic [11:0] out_interface_number;
  logic [10:0] out_wet_total;
  logic        out_last;

  wet_dry_interface_scan u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_cell_req         (in_cell_req),
    .in_face             (in_face),
    .in_point            (in_point),
    .in_status_code      (in_status_code),
    .in_neighbour_cell   (in_neighbour_cell),
    .in_mask_node        (in_mask_node),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_strobe          (out_strobe),
    .out_wet_cell        (out_wet_cell),
    .out_wet_face        (out_wet_face),
    .out_dry_cell        (out_dry_cell),
    .out_dry_face        (out_dry_face),
    .out_back_face_found (out_back_face_found),
    .out_point_slot      (out_point_slot),
    .out_global_node     (out_global_node),
    .out_interface_number(out_interface_number),
    .out_wet_total       (out_wet_total),
    .out_last            (out_last)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // queues between generator, driver and checker
  scan_req_t    pending_reqs[$];
  node_result_t iface_expected[$];
  scan_req_t    cur_req;

  int n_pushed    = 0;
  int n_accepted  = 0;
  int n_scans     = 0;
  int n_checked   = 0;
  int n_settings  = 1;
  int n_fail      = 0;
  int cycle_cnt   = 0;

  // predicted block state
  logic [2:0]  m_status [0:MAX_CELLS-1];
  logic [10:0] m_nbr [0:MAX_CELLS*MAX_FACES-1];
  logic [6:0]  m_mask [0:MAX_FACES*MAX_FPTS-1];
  logic [12:0] m_if_count = '0;
  logic [10:0] m_wet_count = '0;
  logic [2:0]  m_face_count = FACE_COUNT_RST;
  logic [3:0]  m_ppf = POINTS_PER_FACE_RST;
  logic [6:0]  m_ppc = POINTS_PER_CELL_RST;

  // generator's view of which store entries hold data (-1: never written)
  int g_status [0:MAX_CELLS-1];
  int g_nbr [0:MAX_CELLS*MAX_FACES-1];
  bit g_mask [0:MAX_FACES*MAX_FPTS-1];
  int g_nf = 3;
  int g_np = 2;
  int pool [0:POOL_SIZE-1];

  // driver state
  bit req_taken  = 1'b0;
  bit req_live   = 1'b0;
  bit no_idle    = 1'b0;
  int gap_left   = 0;

  // work out the results of one accepted request and update predicted state
  task automatic predict_interface(input scan_req_t rq);
    int nf, np, cid, nb, dry, back, node;
    bit found, have_held;
    node_result_t r, held;
    nf = (int'(m_face_count) > MAX_FACES) ? MAX_FACES : int'(m_face_count);
    np = (int'(m_ppf) > MAX_FPTS) ? MAX_FPTS : int'(m_ppf);
    cid = int'(rq.cell_req);
    have_held = 1'b0;
    held = '0;
    case (rq.op)
      OP_CLEAR: begin
        m_if_count = '0;
        m_wet_count = '0;
      end
      OP_WR_STATUS: m_status[cid] = rq.status;
      OP_WR_NBR:    m_nbr[cid*MAX_FACES + int'(rq.face)] = rq.nbr;
      OP_WR_MASK:   m_mask[int'(rq.face)*MAX_FPTS + int'(rq.point)] = rq.mask;
      OP_SCAN: begin
        if (m_status[cid] == WET_CODE) begin
          m_wet_count = m_wet_count + 11'd1;
          for (int j = 0; j < nf; j++) begin
            nb = int'(m_nbr[cid*MAX_FACES + j]);
            if (nb == 0 || nb > MAX_CELLS) continue;
            dry = nb - 1;
            if (m_status[dry] == WET_CODE) continue;
            back = 0;
            found = 1'b0;
            // last matching face wins
            for (int k = 0; k < nf; k++) begin
              if (int'(m_nbr[dry*MAX_FACES + k]) == cid + 1) begin
                back = k + 1;
                found = 1'b1;
              end
            end
            for (int k = 0; k < np; k++) begin
              node = cid * int'(m_ppc) + int'(m_mask[j*MAX_FPTS + k]);
              r.wet_cell  = 11'(cid + 1);
              r.wet_face  = 3'(j + 1);
              r.dry_cell  = 11'(nb);
              r.dry_face  = 3'(back);
              r.found     = found;
              r.slot      = 3'(k);
              r.gnode     = node[16:0];
              r.ifn       = m_if_count[11:0];
              r.wet_total = m_wet_count;
              r.last      = 1'b0;
              if (have_held) iface_expected.push_back(held);
              held = r;
              have_held = 1'b1;
            end
            m_if_count = m_if_count + 13'd1;
          end
          if (have_held) begin
            held.last = 1'b1;
            iface_expected.push_back(held);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      n_fail++;
    end
  endtask

  // acceptance, register shadowing and result checking at the rising edge
  always @(posedge clk) begin
    node_result_t er;
    cycle_cnt++;
    if (rst_n && start && !busy) begin
      req_taken = 1'b1;
      predict_interface(cur_req);
      if (cur_req.op == OP_SCAN) n_scans++;
      n_accepted++;
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_FACE_COUNT:      m_face_count = cfg_wdata[2:0];
        CFG_POINTS_PER_FACE: m_ppf = cfg_wdata[3:0];
        CFG_POINTS_PER_CELL: m_ppc = cfg_wdata[6:0];
        default: ;
      endcase
    end
    if (rst_n && out_strobe) begin
      if (iface_expected.size() == 0) begin
        $error("unexpected result: wet_cell %0d wet_face %0d", out_wet_cell, out_wet_face);
        n_fail++;
      end else begin
        er = iface_expected.pop_front();
        check_field("wet_cell", er.wet_cell, out_wet_cell);
        check_field("wet_face", er.wet_face, out_wet_face);
        check_field("dry_cell", er.dry_cell, out_dry_cell);
        check_field("dry_face", er.dry_face, out_dry_face);
        check_field("back_face_found", er.found, out_back_face_found);
        check_field("point_slot", er.slot, out_point_slot);
        check_field("global_node", er.gnode, out_global_node);
        check_field("interface_number", er.ifn, out_interface_number);
        check_field("wet_total", er.wet_total, out_wet_total);
        check_field("last", er.last, out_last);
        n_checked++;
      end
    end
  end

  // request driver: new request or gap at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!req_live || req_taken) begin
      if (req_live) begin
        req_live = 1'b0;
        gap_left = no_idle ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      end
      req_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        in_op             <= cur_req.op;
        in_cell_req       <= cur_req.cell_req;
        in_face           <= cur_req.face;
        in_point          <= cur_req.point;
        in_status_code    <= cur_req.status;
        in_neighbour_cell <= cur_req.nbr;
        in_mask_node      <= cur_req.mask;
        start <= 1'b1;
        req_live = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // timeout
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // request with every field random, op fixed
  function automatic scan_req_t rand_req(input logic [2:0] op);
    scan_req_t rq;
    rq.op       = op;
    rq.cell_req = 10'($urandom_range(0, 1023));
    rq.face     = 2'($urandom_range(0, 3));
    rq.point    = 3'($urandom_range(0, 7));
    rq.status   = 3'($urandom_range(0, 7));
    rq.nbr      = 11'($urandom_range(0, 2047));
    rq.mask     = 7'($urandom_range(0, 127));
    return rq;
  endfunction

  task automatic queue_req(input scan_req_t rq);
    case (rq.op)
      OP_WR_STATUS: g_status[rq.cell_req] = int'(rq.status);
      OP_WR_NBR:    g_nbr[int'(rq.cell_req)*MAX_FACES + int'(rq.face)] = int'(rq.nbr);
      OP_WR_MASK:   g_mask[int'(rq.face)*MAX_FPTS + int'(rq.point)] = 1'b1;
      default: ;
    endcase
    pending_reqs.push_back(rq);
    n_pushed++;
  endtask

  task automatic wr_status(input int c, input int s);
    scan_req_t rq;
    rq = rand_req(OP_WR_STATUS);
    rq.cell_req = 10'(c);
    rq.status = 3'(s);
    queue_req(rq);
  endtask

  task automatic wr_nbr(input int c, input int f, input int v);
    scan_req_t rq;
    rq = rand_req(OP_WR_NBR);
    rq.cell_req = 10'(c);
    rq.face = 2'(f);
    rq.nbr = 11'(v);
    queue_req(rq);
  endtask

  task automatic wr_mask(input int f, input int p, input int v);
    scan_req_t rq;
    rq = rand_req(OP_WR_MASK);
    rq.face = 2'(f);
    rq.point = 3'(p);
    rq.mask = 7'(v);
    queue_req(rq);
  endtask

  task automatic do_op(input logic [2:0] op, input int c);
    scan_req_t rq;
    rq = rand_req(op);
    rq.cell_req = 10'(c);
    queue_req(rq);
  endtask

  function automatic int pick_status();
    return ($urandom_range(0, 4) < 2) ? int'(WET_CODE) : int'($urandom_range(0, 7));
  endfunction

  // neighbour mostly from the pool, sometimes none, invalid, itself or any cell
  function automatic int pick_nbr(input int c);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 0;
    if (r < 4) return $urandom_range(MAX_CELLS + 1, 2047);
    if (r == 4) return c + 1;
    if (r == 5) return $urandom_range(1, MAX_CELLS);
    return pool[$urandom_range(0, POOL_SIZE-1)] + 1;
  endfunction

  // first store entry a scan of c would read before it has been written
  function automatic bit find_hole(input int c, output op_t kind, output int idx,
                                  output bit is_back);
    int nb, d;
    is_back = 1'b0;
    kind = OP_WR_STATUS;
    idx = c;
    if (g_status[c] < 0) return 1'b1;
    if (g_status[c] != WET_CODE) return 1'b0;
    for (int j = 0; j < g_nf; j++) begin
      nb = g_nbr[c*MAX_FACES + j];
      if (nb < 0) begin
        kind = OP_WR_NBR;
        idx = c*MAX_FACES + j;
        return 1'b1;
      end
      if (nb == 0 || nb > MAX_CELLS) continue;
      d = nb - 1;
      if (g_status[d] < 0) begin
        kind = OP_WR_STATUS;
        idx = d;
        return 1'b1;
      end
      if (g_status[d] == WET_CODE) continue;
      for (int k = 0; k < g_nf; k++) begin
        if (g_nbr[d*MAX_FACES + k] < 0) begin
          kind = OP_WR_NBR;
          idx = d*MAX_FACES + k;
          is_back = 1'b1;
          return 1'b1;
        end
      end
      for (int k = 0; k < g_np; k++) begin
        if (!g_mask[j*MAX_FPTS + k]) begin
          kind = OP_WR_MASK;
          idx = j*MAX_FPTS + k;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // load whatever the scan would read unwritten, then scan
  task automatic push_scan(input int c);
    op_t kind;
    int idx;
    bit is_back;
    while (find_hole(c, kind, idx, is_back)) begin
      case (kind)
        OP_WR_STATUS:
          wr_status(idx, (idx == c && $urandom_range(0, 3) != 0) ? WET_CODE : pick_status());
        OP_WR_NBR:
          wr_nbr(idx / MAX_FACES, idx % MAX_FACES,
                 (is_back && $urandom_range(0, 1) == 1) ? c + 1 : pick_nbr(idx / MAX_FACES));
        default:
          wr_mask(idx / MAX_FPTS, idx % MAX_FPTS, $urandom_range(0, 127));
      endcase
    end
    do_op(OP_SCAN, c);
  endtask

  // wait for every request to be taken and every result to arrive
  task automatic drain();
    while (!(n_accepted == n_pushed && iface_expected.size() == 0 && !busy))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random requests until n_items more have been queued, loads included
  task automatic random_phase(input int n_items);
    int r, c, base;
    base = n_pushed;
    while (n_pushed - base < n_items) begin
      r = $urandom_range(0, 99);
      c = pool[$urandom_range(0, POOL_SIZE-1)];
      if (r < 40)      push_scan(c);
      else if (r < 55) wr_status(c, pick_status());
      else if (r < 70) wr_nbr(c, $urandom_range(0, 3), pick_nbr(c));
      else if (r < 80) wr_mask($urandom_range(0, 3), $urandom_range(0, 7),
                               $urandom_range(0, 127));
      else if (r < 85) do_op(OP_CLEAR, c);
      else if (r < 89) do_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), c);
      else if (r < 93) wr_status($urandom_range(0, 1023), $urandom_range(0, 7));
      else if (r < 97) wr_nbr($urandom_range(0, 1023), $urandom_range(0, 3),
                              $urandom_range(0, 2047));
      else             push_scan($urandom_range(0, 1023));
    end
  endtask

  // phase settings: face_count, points_per_face, points_per_cell, random requests
  int ph_fc  [0:5] = '{4, 1, 7, 0, 2, 4};
  int ph_ppf [0:5] = '{8, 1, 15, 3, 0, 5};
  int ph_ppc [0:5] = '{64, 1, 127, 0, 5, 100};
  int ph_n   [0:5] = '{90, 70, 80, 30, 30, 80};

  initial begin
    for (int i = 0; i < MAX_CELLS; i++) g_status[i] = -1;
    for (int i = 0; i < MAX_CELLS*MAX_FACES; i++) g_nbr[i] = -1;
    for (int i = 0; i < MAX_FACES*MAX_FPTS; i++) g_mask[i] = 1'b0;
    pool[0] = 0;
    pool[1] = 1;
    pool[2] = MAX_CELLS - 1;
    for (int i = 3; i < POOL_SIZE; i++) pool[i] = $urandom_range(2, MAX_CELLS - 2);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: clear, unused ops, loads at the extremes
    do_op(OP_CLEAR, 0);
    do_op(OP_SPARE_FIRST, 0);
    do_op(OP_SPARE_LAST, MAX_CELLS - 1);
    wr_status(0, WET_CODE);
    wr_status(1, 3);
    wr_status(MAX_CELLS - 1, WET_CODE);
    wr_mask(0, 0, 1);
    wr_mask(0, 1, 127);
    wr_mask(1, 0, 64);
    wr_mask(1, 1, 0);
    wr_mask(2, 0, 2);
    wr_mask(2, 1, 96);
    // cell 0: dry neighbour, no neighbour, wet neighbour
    wr_nbr(0, 0, 2);
    wr_nbr(0, 1, 0);
    wr_nbr(0, 2, MAX_CELLS);
    // cell 1 points back twice, so the later face wins; third face invalid
    wr_nbr(1, 0, 1);
    wr_nbr(1, 1, 1);
    wr_nbr(1, 2, 2047);
    push_scan(0);
    push_scan(1);
    // last cell: dry neighbour without a back face, wet one, one above range
    wr_nbr(MAX_CELLS - 1, 0, 2);
    wr_nbr(MAX_CELLS - 1, 1, 1);
    wr_nbr(MAX_CELLS - 1, 2, MAX_CELLS + 1);
    push_scan(MAX_CELLS - 1);
    push_scan(0);
    do_op(OP_CLEAR, 0);
    push_scan(0);

    // random part under the reset settings, then under each new setting
    random_phase(70);
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(CFG_FACE_COUNT, 7'(ph_fc[p]));
      write_reg(CFG_POINTS_PER_FACE, 7'(ph_ppf[p]));
      write_reg(CFG_POINTS_PER_CELL, 7'(ph_ppc[p]));
      g_nf = (ph_fc[p] > MAX_FACES) ? MAX_FACES : ph_fc[p];
      g_np = (ph_ppf[p] > MAX_FPTS) ? MAX_FPTS : ph_ppf[p];
      n_settings++;
      random_phase(ph_n[p]);
    end
    drain();

    if (iface_expected.size() != 0) begin
      $error("%0d expected results never arrived", iface_expected.size());
      n_fail++;
    end
    $display("Ran %0d requests, %0d of them cell scans, over %0d register settings.",
             n_accepted, n_scans, n_settings);
    $display("Checked %0d interface node results field by field.", n_checked);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/wdis_pkg.sv
src/wdis_ram.sv
src/wdis_emit.sv
src/wdis_seq.sv
src/wet_dry_interface_scan.sv
tb/sv/tb_wet_dry_interface_scan.sv
